>>> sv/gbn_pkg.sv
package gbn_pkg;

	localparam int MAX_WINDOW = 16;
	localparam int SEQ_WIDTH = 16;

	localparam int NUM_W = 17;
	localparam int FRAME_W = 16;
	localparam int WIN_W = 5;
	localparam int TIMER_W = 16;
	localparam int CFG_W = 16;
	localparam int CNT_W = $clog2(MAX_WINDOW + 1);

	localparam logic [FRAME_W-1:0] TIMEOUT_RESET = 16'd500;
	localparam logic [WIN_W-1:0] WINDOW_RESET = 5'd8;
	localparam logic [FRAME_W-1:0] SEQ_MASK = FRAME_W'((64'd1 << SEQ_WIDTH) - 64'd1);

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_ACK = 2'd1,
		OP_TICK = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		KIND_NEW = 2'd0,
		KIND_RESEND = 2'd1,
		KIND_DONE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		REG_FRAME_COUNT = 2'd0,
		REG_WINDOW_SIZE = 2'd1,
		REG_TIMEOUT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame_count;
		logic [WIN_W-1:0] window_size;
		logic [FRAME_W-1:0] timeout_ticks;
	} cfg_t;

	// operands and result of the shared add/compare unit
	typedef struct packed {
		logic [NUM_W-1:0] a;
		logic [CNT_W-1:0] addend;
		logic [NUM_W-1:0] b1;
		logic [NUM_W-1:0] b2;
	} cmp_op_t;

	typedef struct packed {
		logic [NUM_W-1:0] sum;
		logic lt1;
		logic lt2;
	} cmp_res_t;

	// sequencer to result buffer
	typedef struct packed {
		logic push;
		logic close;
		logic [1:0] kind;
		logic [FRAME_W-1:0] seq;
	} buf_req_t;

	typedef struct packed {
		logic take;
		logic done;
	} buf_stat_t;

	function automatic logic [CNT_W-1:0] eff_window(input logic [WIN_W-1:0] ws);
		logic [CNT_W-1:0] w;
		if (ws == '0) begin
			w = CNT_W'(1);
		end else if (int'(ws) > MAX_WINDOW) begin
			w = CNT_W'(MAX_WINDOW);
		end else begin
			w = CNT_W'(ws);
		end
		return w;
	endfunction

	function automatic logic [FRAME_W-1:0] seq_of(input logic [NUM_W-1:0] v);
		return FRAME_W'(v) & SEQ_MASK;
	endfunction

endpackage

>>> sv/gbn_in_if.sv
interface gbn_in_if;
	logic valid;
	logic ready;
	logic [1:0] op;
	logic signed [gbn_pkg::NUM_W-1:0] ack_number;

	modport source(output valid, output op, output ack_number, input ready);
	modport sink(input valid, input op, input ack_number, output ready);
endinterface

>>> sv/gbn_out_if.sv
interface gbn_out_if;
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [gbn_pkg::FRAME_W-1:0] frame_seq;
	logic last_of_run;

	modport source(output valid, output kind, output frame_seq, output last_of_run, input ready);
	modport sink(input valid, input kind, input frame_seq, input last_of_run, output ready);
endinterface

>>> sv/go_back_n_sender_window.sv
// Channel   Dir  Payload                          Beat when
// items     in   op, ack_number                   items.valid && items.ready
// results   out  kind, frame_seq, last_of_run     results.valid && results.ready
// cfg       in   cfg_index, cfg_data              cfg_write
//
// Ack: ACK1, ACK2, FLUSH; an ignored ack skips ACK2. Tick: TICK1, FLUSH. Unknown op:
// FLUSH. Start: START, PREP, SEND, FLUSH; an empty transfer goes from START to FLUSH.
// Period end: TICK2, RESEND if unacked, PREP, SEND; completion in TICK2. Compute steps
// run through the single add/compare unit. A stalled results channel holds the sequencer.
// Reset clears the window state and loads the register defaults; no clearing pass.
module go_back_n_sender_window (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [1:0]                   cfg_index,
	input  logic [gbn_pkg::CFG_W-1:0]    cfg_data,
	gbn_in_if.sink                       items,
	gbn_out_if.source                    results
);

	gbn_pkg::cfg_t cfg_q;
	gbn_pkg::cmp_op_t cmp_op;
	gbn_pkg::cmp_res_t cmp_res;
	gbn_pkg::buf_req_t req;
	gbn_pkg::buf_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_count <= '0;
			cfg_q.window_size <= gbn_pkg::WINDOW_RESET;
			cfg_q.timeout_ticks <= gbn_pkg::TIMEOUT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				gbn_pkg::REG_FRAME_COUNT: cfg_q.frame_count <= cfg_data;
				gbn_pkg::REG_WINDOW_SIZE: cfg_q.window_size <= cfg_data[gbn_pkg::WIN_W-1:0];
				gbn_pkg::REG_TIMEOUT: cfg_q.timeout_ticks <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	gbn_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.items   (items),
		.cmp_op  (cmp_op),
		.cmp_res (cmp_res),
		.req     (req),
		.stat    (stat)
	);

	gbn_cmp u_cmp (
		.op  (cmp_op),
		.res (cmp_res)
	);

	gbn_res_buf u_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.stat    (stat),
		.results (results)
	);

endmodule

>>> sv/gbn_cmp.sv
module gbn_cmp (
	input  gbn_pkg::cmp_op_t  op,
	output gbn_pkg::cmp_res_t res
);

	logic [gbn_pkg::NUM_W-1:0] sum;

	assign sum = op.a + gbn_pkg::NUM_W'(op.addend);

	always_comb begin
		res.sum = sum;
		res.lt1 = sum < op.b1;
		res.lt2 = sum < op.b2;
	end

endmodule

>>> sv/gbn_res_buf.sv
module gbn_res_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  gbn_pkg::buf_req_t   req,
	output gbn_pkg::buf_stat_t  stat,
	gbn_out_if.source           results
);

	logic pend_valid_q;
	logic [1:0] pend_kind_q;
	logic [gbn_pkg::FRAME_W-1:0] pend_seq_q;

	logic out_valid_q;
	logic [1:0] out_kind_q;
	logic [gbn_pkg::FRAME_W-1:0] out_seq_q;
	logic out_last_q;

	logic out_free;
	logic move;
	logic move_last;

	assign out_free = !out_valid_q || results.ready;

	always_comb begin
		stat.take = req.push && (!pend_valid_q || out_free);
		stat.done = req.close && (!pend_valid_q || out_free);
		// the held result goes out once we know whether another follows it
		move = pend_valid_q && out_free && (req.push || req.close);
		move_last = req.close;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (stat.take) begin
				pend_valid_q <= 1'b1;
			end else if (move) begin
				pend_valid_q <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= move;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stat.take) begin
			pend_kind_q <= req.kind;
			pend_seq_q <= req.seq;
		end
		if (move) begin
			out_kind_q <= pend_kind_q;
			out_seq_q <= pend_seq_q;
			out_last_q <= move_last;
		end
	end

	assign results.valid = out_valid_q;
	assign results.kind = out_kind_q;
	assign results.frame_seq = out_seq_q;
	assign results.last_of_run = out_last_q;

endmodule

>>> sv/gbn_seq.sv
module gbn_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  gbn_pkg::cfg_t       cfg,
	gbn_in_if.sink              items,
	output gbn_pkg::cmp_op_t    cmp_op,
	input  gbn_pkg::cmp_res_t   cmp_res,
	output gbn_pkg::buf_req_t   req,
	input  gbn_pkg::buf_stat_t  stat
);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_START  = 10'b00_0000_0010,
		S_ACK1   = 10'b00_0000_0100,
		S_ACK2   = 10'b00_0000_1000,
		S_TICK1  = 10'b00_0001_0000,
		S_TICK2  = 10'b00_0010_0000,
		S_RESEND = 10'b00_0100_0000,
		S_PREP   = 10'b00_1000_0000,
		S_SEND   = 10'b01_0000_0000,
		S_FLUSH  = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	logic [gbn_pkg::NUM_W-1:0] base_q;
	logic [gbn_pkg::NUM_W-1:0] next_q;
	logic [gbn_pkg::TIMER_W-1:0] timer_q;
	logic acked_q;
	logic active_q;
	logic resend_q;
	logic [gbn_pkg::NUM_W-1:0] cursor_q;
	logic [gbn_pkg::NUM_W-1:0] lim_q;
	logic [gbn_pkg::CNT_W-1:0] n_q;
	logic signed [gbn_pkg::NUM_W-1:0] ack_q;

	logic accept;
	logic room;
	logic hit;
	logic finish;
	logic [gbn_pkg::NUM_W-1:0] count_ext;
	logic [gbn_pkg::NUM_W-1:0] tmo_ext;

	assign items.ready = (state_q == S_IDLE);
	assign accept = items.valid && items.ready;
	assign count_ext = gbn_pkg::NUM_W'(cfg.frame_count);
	assign tmo_ext = (cfg.timeout_ticks == '0) ? gbn_pkg::NUM_W'(1)
		: gbn_pkg::NUM_W'(cfg.timeout_ticks);
	assign room = n_q < gbn_pkg::CNT_W'(gbn_pkg::MAX_WINDOW);

	// operand select for the shared unit
	always_comb begin
		cmp_op.a = '0;
		cmp_op.addend = '0;
		cmp_op.b1 = '1;
		cmp_op.b2 = '1;
		case (state_q)
			S_START: begin
				cmp_op.b2 = count_ext;
			end
			S_ACK1: begin
				cmp_op.a = ack_q;
				cmp_op.b1 = base_q;
				cmp_op.b2 = count_ext;
			end
			S_ACK2: begin
				cmp_op.a = ack_q;
				cmp_op.addend = gbn_pkg::CNT_W'(1);
				cmp_op.b1 = next_q;
				cmp_op.b2 = count_ext;
			end
			S_TICK1: begin
				cmp_op.a = gbn_pkg::NUM_W'(timer_q);
				cmp_op.addend = gbn_pkg::CNT_W'(1);
				cmp_op.b1 = tmo_ext;
			end
			S_TICK2: begin
				cmp_op.a = base_q;
				cmp_op.b2 = count_ext;
			end
			S_RESEND: begin
				cmp_op.a = cursor_q;
				cmp_op.b1 = next_q;
				cmp_op.b2 = count_ext;
			end
			S_PREP: begin
				cmp_op.a = base_q;
				cmp_op.addend = gbn_pkg::eff_window(cfg.window_size);
			end
			S_SEND: begin
				cmp_op.a = next_q;
				cmp_op.b1 = lim_q;
				cmp_op.b2 = count_ext;
			end
			default: begin
				cmp_op.a = '0;
			end
		endcase
	end

	always_comb begin
		hit = (state_q == S_RESEND || state_q == S_SEND) && cmp_res.lt1 && cmp_res.lt2 && room;
		finish = (state_q == S_START || state_q == S_ACK2 || state_q == S_TICK2) && !cmp_res.lt2;
		req.push = hit || finish;
		req.close = (state_q == S_FLUSH);
		if (finish) begin
			req.kind = gbn_pkg::KIND_DONE;
			req.seq = '0;
		end else if (state_q == S_RESEND) begin
			req.kind = gbn_pkg::KIND_RESEND;
			req.seq = gbn_pkg::seq_of(cursor_q);
		end else begin
			req.kind = gbn_pkg::KIND_NEW;
			req.seq = gbn_pkg::seq_of(next_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			base_q <= '0;
			next_q <= '0;
			timer_q <= '0;
			acked_q <= 1'b0;
			active_q <= 1'b0;
			resend_q <= 1'b0;
			cursor_q <= '0;
			lim_q <= '0;
			n_q <= '0;
			ack_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						n_q <= '0;
						case (items.op)
							gbn_pkg::OP_START: begin
								base_q <= '0;
								next_q <= '0;
								timer_q <= '0;
								acked_q <= 1'b0;
								active_q <= 1'b1;
								state_q <= S_START;
							end
							gbn_pkg::OP_ACK: begin
								ack_q <= items.ack_number;
								state_q <= S_ACK1;
							end
							gbn_pkg::OP_TICK: begin
								state_q <= S_TICK1;
							end
							default: begin
								state_q <= S_FLUSH;
							end
						endcase
					end
				end
				S_START: begin
					if (finish) begin
						if (stat.take) begin
							active_q <= 1'b0;
							state_q <= S_FLUSH;
						end
					end else begin
						state_q <= S_PREP;
					end
				end
				S_ACK1: begin
					// accept only acks in [base, count)
					if (active_q && !ack_q[gbn_pkg::NUM_W-1] && !cmp_res.lt1 && cmp_res.lt2) begin
						state_q <= S_ACK2;
					end else begin
						state_q <= S_FLUSH;
					end
				end
				S_ACK2: begin
					base_q <= cmp_res.sum;
					acked_q <= 1'b1;
					if (!cmp_res.lt1) begin
						next_q <= cmp_res.sum;
					end
					if (finish) begin
						if (stat.take) begin
							active_q <= 1'b0;
							state_q <= S_FLUSH;
						end
					end else begin
						state_q <= S_FLUSH;
					end
				end
				S_TICK1: begin
					if (!active_q) begin
						state_q <= S_FLUSH;
					end else if (cmp_res.lt1) begin
						timer_q <= gbn_pkg::TIMER_W'(cmp_res.sum);
						state_q <= S_FLUSH;
					end else begin
						// period over: clear timer and ack mark, remember whether to resend
						timer_q <= '0;
						resend_q <= !acked_q;
						acked_q <= 1'b0;
						state_q <= S_TICK2;
					end
				end
				S_TICK2: begin
					if (finish) begin
						if (stat.take) begin
							active_q <= 1'b0;
							state_q <= S_FLUSH;
						end
					end else begin
						cursor_q <= base_q;
						state_q <= resend_q ? S_RESEND : S_PREP;
					end
				end
				S_RESEND: begin
					if (hit) begin
						if (stat.take) begin
							cursor_q <= cursor_q + gbn_pkg::NUM_W'(1);
							n_q <= n_q + gbn_pkg::CNT_W'(1);
						end
					end else begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					lim_q <= cmp_res.sum;
					state_q <= S_SEND;
				end
				S_SEND: begin
					if (hit) begin
						if (stat.take) begin
							next_q <= next_q + gbn_pkg::NUM_W'(1);
							n_q <= n_q + gbn_pkg::CNT_W'(1);
						end
					end else begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (stat.done) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> sv/gbn_checker.sv
module gbn_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [1:0]                    out_kind,
	input logic [gbn_pkg::FRAME_W-1:0]   out_seq,
	input logic                          out_last
);

	// hold a stalled beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_kind) && $stable(out_seq) && $stable(out_last))
		else $error("stalled result payload changed");

	// completion is always alone and carries sequence zero
	a_done_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == gbn_pkg::KIND_DONE |-> out_seq == '0 && out_last)
		else $error("malformed completion result");

	// one item at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

endmodule

bind go_back_n_sender_window gbn_checker u_gbn_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (items.valid),
	.in_ready  (items.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_kind  (results.kind),
	.out_seq   (results.frame_seq),
	.out_last  (results.last_of_run)
);

>>> verif/gbn_checker.sv
`timescale 1ns / 100ps
module gbn_tb_checker (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [1:0]               cfg_index,
	input  logic [gbn_pkg::CFG_W-1:0] cfg_data,
	gbn_in_if                        items,
	gbn_out_if                       results,
	output int                       mismatches,
	output int                       pending
);

	typedef struct packed {
		gbn_pkg::kind_t              kind;
		logic [gbn_pkg::FRAME_W-1:0] seq;
		logic                        last;
	} frame_order_t;

	// register copies
	logic [gbn_pkg::FRAME_W-1:0] n_frames;
	logic [gbn_pkg::WIN_W-1:0]   win_cfg;
	logic [gbn_pkg::TIMER_W-1:0] timeout_cfg;

	// window state
	logic [gbn_pkg::NUM_W-1:0]   win_base;
	logic [gbn_pkg::NUM_W-1:0]   next_seq;
	logic [gbn_pkg::TIMER_W-1:0] tick_count;
	logic                        acked_flag;
	logic                        xfer_active;

	frame_order_t burst[$];
	frame_order_t order_q[$];
	int bad_count;

	function automatic int window_span();
		if (win_cfg == '0)
			return 1;
		if (int'(win_cfg) > gbn_pkg::MAX_WINDOW)
			return gbn_pkg::MAX_WINDOW;
		return int'(win_cfg);
	endfunction

	task automatic emit(input gbn_pkg::kind_t k, input logic [gbn_pkg::NUM_W-1:0] v);
		frame_order_t o;
		if (burst.size() < gbn_pkg::MAX_WINDOW) begin
			o.kind = k;
			o.seq = v[gbn_pkg::FRAME_W-1:0];
			o.last = 1'b0;
			burst = {burst, o};
		end
	endtask

	task automatic close_transfer();
		emit(gbn_pkg::KIND_DONE, '0);
		xfer_active = 1'b0;
	endtask

	task automatic push_new_frames();
		int lim;
		lim = int'(win_base) + window_span();
		while (int'(next_seq) < lim && next_seq < gbn_pkg::NUM_W'(n_frames) &&
				burst.size() < gbn_pkg::MAX_WINDOW) begin
			emit(gbn_pkg::KIND_NEW, next_seq);
			next_seq++;
		end
	endtask

	task automatic predict_orders(input logic [1:0] op,
			input logic signed [gbn_pkg::NUM_W-1:0] ack);
		int a;
		int lim;
		a = int'(ack);
		burst.delete();
		case (op)
			gbn_pkg::OP_START: begin
				win_base = '0;
				next_seq = '0;
				tick_count = '0;
				acked_flag = 1'b0;
				xfer_active = 1'b1;
				if (n_frames == '0)
					close_transfer();
				else
					push_new_frames();
			end
			gbn_pkg::OP_ACK: begin
				if (xfer_active && a >= int'(win_base) && a < int'(n_frames)) begin
					win_base = gbn_pkg::NUM_W'(a + 1);
					acked_flag = 1'b1;
					if (next_seq < win_base)
						next_seq = win_base;
					if (win_base >= gbn_pkg::NUM_W'(n_frames))
						close_transfer();
				end
			end
			gbn_pkg::OP_TICK: begin
				if (xfer_active) begin
					lim = (timeout_cfg == '0) ? 1 : int'(timeout_cfg);
					tick_count = tick_count + 1'b1;
					if (int'(tick_count) >= lim) begin
						if (win_base >= gbn_pkg::NUM_W'(n_frames)) begin
							close_transfer();
						end else begin
							// unacked period: go back to the base
							if (!acked_flag)
								for (int f = int'(win_base); f < int'(next_seq) &&
										f < int'(n_frames) &&
										burst.size() < gbn_pkg::MAX_WINDOW; f++)
									emit(gbn_pkg::KIND_RESEND, gbn_pkg::NUM_W'(f));
							push_new_frames();
						end
						tick_count = '0;
						acked_flag = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
		if (burst.size() > 0)
			burst[burst.size() - 1].last = 1'b1;
		foreach (burst[j])
			order_q = {order_q, burst[j]};
	endtask

	task automatic check_order();
		frame_order_t want;
		if (order_q.size() == 0) begin
			if (bad_count < 10)
				$display("%0t: result with nothing pending: kind %0d seq %0d last %0b",
					$realtime, results.kind, results.frame_seq, results.last_of_run);
			bad_count++;
		end else begin
			want = order_q.pop_front();
			if (results.kind !== want.kind || results.frame_seq !== want.seq ||
					results.last_of_run !== want.last) begin
				if (bad_count < 10)
					$display("%0t: mismatch: got kind %0d seq %0d last %0b,",
						$realtime, results.kind, results.frame_seq, results.last_of_run,
						" want kind %0d seq %0d last %0b",
						want.kind, want.seq, want.last);
				bad_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_frames = '0;
			win_cfg = gbn_pkg::WINDOW_RESET;
			timeout_cfg = gbn_pkg::TIMEOUT_RESET;
			win_base = '0;
			next_seq = '0;
			tick_count = '0;
			acked_flag = 1'b0;
			xfer_active = 1'b0;
			order_q.delete();
			bad_count = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					gbn_pkg::REG_FRAME_COUNT: n_frames = cfg_data[gbn_pkg::FRAME_W-1:0];
					gbn_pkg::REG_WINDOW_SIZE: win_cfg = cfg_data[gbn_pkg::WIN_W-1:0];
					gbn_pkg::REG_TIMEOUT:     timeout_cfg = cfg_data[gbn_pkg::TIMER_W-1:0];
					default: begin
					end
				endcase
			end
			if (items.valid && items.ready)
				predict_orders(items.op, items.ack_number);
			if (results.valid && results.ready)
				check_order();
			mismatches <= bad_count;
			pending <= order_q.size();
		end
	end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
module tb;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int LONG_HOLD = 120;
	localparam int DRAIN_CYCLES = 16;
	localparam int END_CYCLES = 40;
	localparam int QUIET_LIMIT = 3000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 18;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_write;
	logic [1:0]                cfg_index;
	logic [gbn_pkg::CFG_W-1:0] cfg_data;
	int                        mismatches;
	int                        pending;
	bit                        idle_on = 1'b1;
	bit                        hold_req = 1'b0;
	bit                        hold_done = 1'b0;

	gbn_in_if  items_ch();
	gbn_out_if results_ch();

	go_back_n_sender_window dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.items     (items_ch),
		.results   (results_ch)
	);

	gbn_tb_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.items      (items_ch),
		.results    (results_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_item(input logic [1:0] op,
			input logic signed [gbn_pkg::NUM_W-1:0] ack);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			items_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		items_ch.valid <= 1'b1;
		items_ch.op <= op;
		items_ch.ack_number <= ack;
		@(posedge clk);
		while (!items_ch.ready) @(posedge clk);
	endtask

	// drop valid, wait out pending orders, then let the block go quiet
	task automatic settle(input int tail);
		items_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic configure(input logic [gbn_pkg::CFG_W-1:0] frames, win, ticks);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= gbn_pkg::REG_FRAME_COUNT;
		cfg_data <= frames;
		@(posedge clk);
		cfg_index <= gbn_pkg::REG_WINDOW_SIZE;
		cfg_data <= win;
		@(posedge clk);
		cfg_index <= gbn_pkg::REG_TIMEOUT;
		cfg_data <= ticks;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// result side: short random stalls, one long hold-off on request
	initial begin
		results_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				results_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_done = 1'b1;
				results_ch.ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				results_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				results_ch.ready <= 1'b1;
			end else begin
				results_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int sel;
		int ack;
		int stale;
		int next_ack;
		logic [gbn_pkg::CFG_W-1:0] frames;
		logic [gbn_pkg::CFG_W-1:0] ticks;

		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= gbn_pkg::REG_FRAME_COUNT;
		cfg_data <= '0;
		items_ch.valid <= 1'b0;
		items_ch.op <= gbn_pkg::OP_START;
		items_ch.ack_number <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// empty transfer, idle acks and ticks, unknown op
		configure(16'd0, 16'd8, 16'd3);
		send_item(gbn_pkg::OP_ACK, 17'sd0);
		send_item(gbn_pkg::OP_TICK, 17'sd0);
		send_item(gbn_pkg::OP_START, 17'sd0);
		send_item(OP_UNUSED, -17'sd1);
		settle(DRAIN_CYCLES);

		// window 0 acts as 1, timeout 0 acts as 1
		configure(16'd5, 16'd0, 16'd0);
		send_item(gbn_pkg::OP_START, 17'sd0);
		send_item(gbn_pkg::OP_TICK, 17'sd0);
		send_item(gbn_pkg::OP_ACK, 17'sd0);
		send_item(gbn_pkg::OP_TICK, 17'sd0);
		send_item(gbn_pkg::OP_ACK, -17'sd1);
		send_item(gbn_pkg::OP_ACK, 17'sd7);
		send_item(gbn_pkg::OP_ACK, 17'sd3);
		send_item(gbn_pkg::OP_TICK, 17'sd0);
		send_item(gbn_pkg::OP_START, 17'sd0);
		send_item(gbn_pkg::OP_ACK, 17'sd4);
		settle(DRAIN_CYCLES);

		// lower the count under an open transfer
		configure(16'd10, 16'd4, 16'd2);
		send_item(gbn_pkg::OP_START, 17'sd0);
		send_item(gbn_pkg::OP_ACK, 17'sd5);
		settle(DRAIN_CYCLES);
		configure(16'd3, 16'd4, 16'd2);
		send_item(gbn_pkg::OP_TICK, 17'sd0);
		send_item(gbn_pkg::OP_TICK, 17'sd0);
		settle(DRAIN_CYCLES);

		// top of the sequence space, full windows; hold results so the block backs up
		configure(16'hFFFF, 16'hFFF0, 16'hFFFF);
		hold_req = 1'b1;
		send_item(gbn_pkg::OP_START, 17'sd0);
		send_item(gbn_pkg::OP_ACK, 17'sd65533);
		send_item(gbn_pkg::OP_ACK, 17'sd65535);
		send_item(gbn_pkg::OP_TICK, 17'sd0);
		settle(DRAIN_CYCLES);
		configure(16'hFFFF, 16'd31, 16'd1);
		send_item(gbn_pkg::OP_TICK, 17'sd0);
		send_item(gbn_pkg::OP_ACK, 17'sd65534);
		send_item(gbn_pkg::OP_START, 17'sd0);
		send_item(gbn_pkg::OP_TICK, 17'sd0);
		settle(DRAIN_CYCLES);

		for (int ph = 0; ph < PHASES; ph++) begin
			sel = $urandom_range(0, 9);
			if (sel == 0)
				frames = '0;
			else if (sel == 1)
				frames = 16'hFFFF;
			else if (sel == 2)
				frames = 16'($urandom_range(100, 65535));
			else
				frames = 16'($urandom_range(1, 30));
			sel = $urandom_range(0, 9);
			if (sel == 0)
				ticks = '0;
			else if (sel == 1)
				ticks = 16'hFFFF;
			else
				ticks = 16'($urandom_range(1, 6));
			configure(frames, 16'($urandom_range(0, 31)), ticks);
			idle_on = ph < PHASES - 1 && $urandom_range(0, 3) != 0;
			next_ack = 0;
			send_item(gbn_pkg::OP_START, gbn_pkg::NUM_W'($urandom));
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				sel = $urandom_range(0, 99);
				if (next_ack >= int'(frames) || sel < 5) begin
					send_item(gbn_pkg::OP_START, gbn_pkg::NUM_W'($urandom));
					next_ack = 0;
				end else if (sel < 50) begin
					send_item(gbn_pkg::OP_TICK, gbn_pkg::NUM_W'($urandom));
				end else if (sel < 88) begin
					// mostly in-order acks, sometimes a jump toward the end
					if (frames > 40 && $urandom_range(0, 3) == 0)
						ack = int'(frames) - int'($urandom_range(1, 20));
					else
						ack = next_ack + int'($urandom_range(0, 2));
					send_item(gbn_pkg::OP_ACK, gbn_pkg::NUM_W'(ack));
					next_ack = ack + 1;
				end else if (sel < 93) begin
					stale = next_ack - 1 - int'($urandom_range(0, 2));
					if (stale < -1)
						stale = -1;
					send_item(gbn_pkg::OP_ACK, gbn_pkg::NUM_W'(stale));
				end else begin
					send_item(OP_UNUSED, gbn_pkg::NUM_W'($urandom));
				end
			end
			settle(DRAIN_CYCLES);
		end

		settle(END_CYCLES);
		if (mismatches == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
